>>> rtl/core/dptd_pkg.sv
// ----------------------------------------------------------------------------
// dptd_pkg: shared types and constants of the dive profile token decoder
// Holds the parse phases, the command codes that pass from the parser to the
// executer, and the command queue geometry.
// ----------------------------------------------------------------------------
package dptd_pkg;

	// Parse phase of the byte-level token parser
	typedef enum logic [2:0] {
		PH_LEAD      = 3'd0,
		PH_ALARM     = 3'd1,
		PH_TEMP_HI   = 3'd2,
		PH_TEMP_LO   = 3'd3,
		PH_DEPTH_HI  = 3'd4,
		PH_DEPTH_LO  = 3'd5,
		PH_TDELTA_LO = 3'd6,
		PH_DDELTA_LO = 3'd7
	} phase_t;

	// Decoded command handed to the executer
	typedef enum logic [2:0] {
		OP_SET_TEMP  = 3'd0,
		OP_ADD_TEMP  = 3'd1,
		OP_SET_DEPTH = 3'd2,
		OP_ADD_DEPTH = 3'd3,
		OP_TICK      = 3'd4,
		OP_ALARM     = 3'd5
	} op_t;

	// Command value width: widest payload is the 17-bit absolute depth
	localparam int unsigned VAL_W = 17;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
	} cmd_t;

	// Command queue between parser and executer
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

	// Output field widths
	localparam int unsigned OUT_ACC_W  = 24;
	localparam int unsigned OUT_TIME_W = 32;
	localparam int unsigned CODE_W     = 7;

	// Configuration register indexes
	localparam logic REG_SECONDS_PER_TICK = 1'b0;
	localparam logic [3:0] SPT_RESET = 4'd4;

	// Record kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_ALARM  = 1'b1;

endpackage

>>> rtl/core/dptd_front.sv
// ----------------------------------------------------------------------------
// dptd_front: token parser
// Walks the byte stream, gathers multi-byte payloads and turns each complete
// token into one command for the executer. Marks produce no command.
// ----------------------------------------------------------------------------
module dptd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      byte_in,
	output logic            push,
	output dptd_pkg::cmd_t  cmd
);

	dptd_pkg::phase_t phase_q, phase_d;
	logic [2:0]       lead_q, lead_d;
	logic [7:0]       partial_q, partial_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dptd_pkg::PH_LEAD;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		lead_q    <= lead_d;
		partial_q <= partial_d;
	end

	always_comb begin
		phase_d   = phase_q;
		lead_d    = lead_q;
		partial_d = partial_q;
		push      = 1'b0;
		cmd.op    = dptd_pkg::OP_TICK;
		cmd.value = '0;
		if (take) begin
			unique case (phase_q)
				dptd_pkg::PH_ALARM: begin
					phase_d = dptd_pkg::PH_LEAD;
					push    = 1'b1;
					cmd.op  = dptd_pkg::OP_ALARM;
					// only a single bit among the low seven is a known code
					if (!byte_in[7] && $onehot(byte_in[6:0])) begin
						cmd.value = {10'd0, byte_in[6:0]};
					end
				end
				dptd_pkg::PH_TEMP_HI: begin
					partial_d = byte_in;
					phase_d   = dptd_pkg::PH_TEMP_LO;
				end
				dptd_pkg::PH_TEMP_LO: begin
					phase_d   = dptd_pkg::PH_LEAD;
					push      = 1'b1;
					cmd.op    = dptd_pkg::OP_SET_TEMP;
					cmd.value = {1'b0, partial_q, byte_in};
				end
				dptd_pkg::PH_DEPTH_HI: begin
					partial_d = byte_in;
					phase_d   = dptd_pkg::PH_DEPTH_LO;
				end
				dptd_pkg::PH_DEPTH_LO: begin
					phase_d   = dptd_pkg::PH_LEAD;
					push      = 1'b1;
					cmd.op    = dptd_pkg::OP_SET_DEPTH;
					cmd.value = {lead_q[0], partial_q, byte_in};
				end
				dptd_pkg::PH_TDELTA_LO: begin
					phase_d   = dptd_pkg::PH_LEAD;
					push      = 1'b1;
					cmd.op    = dptd_pkg::OP_ADD_TEMP;
					cmd.value = {{7{lead_q[1]}}, lead_q[1:0], byte_in};
				end
				dptd_pkg::PH_DDELTA_LO: begin
					phase_d   = dptd_pkg::PH_LEAD;
					push      = 1'b1;
					cmd.op    = dptd_pkg::OP_ADD_DEPTH;
					cmd.value = {{6{lead_q[2]}}, lead_q[2:0], byte_in};
				end
				dptd_pkg::PH_LEAD: begin
					lead_d = byte_in[2:0];
					priority if (byte_in == 8'hFF) begin
						phase_d = dptd_pkg::PH_ALARM;
					end else if (byte_in == 8'hFE) begin
						phase_d = dptd_pkg::PH_TEMP_HI;
					end else if (byte_in[7:1] == 7'b1111110) begin
						phase_d = dptd_pkg::PH_DEPTH_HI;
					end else if (byte_in[7:2] == 6'b111110) begin
						phase_d = dptd_pkg::PH_TDELTA_LO;
					end else if (byte_in[7:3] == 5'b11110) begin
						phase_d = dptd_pkg::PH_DDELTA_LO;
					end else if (byte_in[7:4] == 4'b1110) begin
						// mark: drop
					end else if (byte_in[7:5] == 3'b110) begin
						push      = 1'b1;
						cmd.op    = dptd_pkg::OP_TICK;
						cmd.value = {12'd0, byte_in[4:0]};
					end else if (byte_in[7:6] == 2'b10) begin
						push      = 1'b1;
						cmd.op    = dptd_pkg::OP_ADD_TEMP;
						cmd.value = {{11{byte_in[5]}}, byte_in[5:0]};
					end else begin
						push      = 1'b1;
						cmd.op    = dptd_pkg::OP_ADD_DEPTH;
						cmd.value = {{10{byte_in[6]}}, byte_in[6:0]};
					end
				end
			endcase
		end
	end

endmodule

>>> rtl/core/dptd_queue.sv
// ----------------------------------------------------------------------------
// dptd_queue: command queue
// Short first-in first-out buffer that decouples the parser from the executer.
// ----------------------------------------------------------------------------
module dptd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dptd_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output dptd_pkg::cmd_t  head_cmd
);

	dptd_pkg::cmd_t                  entry_q [dptd_pkg::Q_DEPTH];
	logic [dptd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [dptd_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	assign full       = (count_q == dptd_pkg::QCNT_W'(dptd_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [dptd_pkg::QPTR_W-1:0] wrap_inc(
		input logic [dptd_pkg::QPTR_W-1:0] p
	);
		if (p == dptd_pkg::QPTR_W'(dptd_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dptd_pkg::QCNT_W'(dptd_pkg::Q_DEPTH))
		else $error("command queue count beyond depth");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted command not counted");

endmodule

>>> rtl/core/dptd_back.sv
// ----------------------------------------------------------------------------
// dptd_back: command executer
// Applies commands to the depth, offset, temperature and time accumulators
// and loads the record register for samples and alarms.
// ----------------------------------------------------------------------------
module dptd_back #(
	parameter int unsigned ACC_BITS  = 24,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [3:0]              seconds_per_tick,
	input  logic                    head_valid,
	input  dptd_pkg::cmd_t          head_cmd,
	output logic                    pop,
	output logic                    record_valid,
	input  logic                    record_stall,
	output logic                    record_kind,
	output logic [31:0]             elapsed_seconds,
	output logic signed [23:0]      relative_depth,
	output logic signed [23:0]      temperature,
	output logic [6:0]              alarm_code
);

	localparam int unsigned A  = ACC_BITS;
	localparam int unsigned VW = dptd_pkg::VAL_W;
	localparam int unsigned WX = (A > dptd_pkg::OUT_ACC_W) ? A : dptd_pkg::OUT_ACC_W;
	localparam int unsigned WT = (TIME_BITS > dptd_pkg::OUT_TIME_W) ?
		TIME_BITS : dptd_pkg::OUT_TIME_W;

	logic signed [A-1:0]     depth_q, offset_q, temp_q;
	logic signed [A-1:0]     depth_d, offset_d, temp_d;
	logic [TIME_BITS-1:0]    elapsed_q, elapsed_d;
	logic                    rec_valid_q;
	logic                    emits, out_free;
	logic [4:0]              mult;
	logic [8:0]              add_secs;
	logic [TIME_BITS:0]      time_sum;
	logic signed [A:0]       temp_sum, depth_sum, rel_diff;
	logic signed [A-1:0]     rel_acc;
	logic signed [A:0]       delta;
	logic signed [WX-1:0]    rel_x, temp_x;
	logic [WT-1:0]           time_x;
	logic signed [23:0]      rel_out, temp_out;
	logic [31:0]             time_out;

	localparam logic signed [A-1:0] ACC_MAX = {1'b0, {(A-1){1'b1}}};
	localparam logic signed [A-1:0] ACC_MIN = {1'b1, {(A-1){1'b0}}};

	function automatic logic signed [A-1:0] sat_acc(input logic signed [A:0] v);
		if (v[A] != v[A-1]) begin
			return v[A] ? ACC_MIN : ACC_MAX;
		end
		return v[A-1:0];
	endfunction

	function automatic logic signed [23:0] sat_out(input logic signed [WX-1:0] v);
		if (v > WX'(24'sh7FFFFF)) begin
			return 24'sh7FFFFF;
		end
		if (v < WX'(24'sh800000)) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	assign emits = (head_cmd.op == dptd_pkg::OP_SET_DEPTH) ||
		(head_cmd.op == dptd_pkg::OP_ADD_DEPTH) ||
		(head_cmd.op == dptd_pkg::OP_TICK) ||
		(head_cmd.op == dptd_pkg::OP_ALARM);
	assign out_free = !rec_valid_q || !record_stall;
	assign pop      = head_valid && (!emits || out_free);

	assign delta     = {{(A + 1 - VW){head_cmd.value[VW-1]}}, head_cmd.value};
	assign temp_sum  = {temp_q[A-1], temp_q} + delta;
	assign depth_sum = {depth_q[A-1], depth_q} + delta;

	always_comb begin
		depth_d  = depth_q;
		offset_d = offset_q;
		temp_d   = temp_q;
		mult     = 5'd0;
		unique case (head_cmd.op)
			dptd_pkg::OP_SET_TEMP: begin
				temp_d = {{(A - VW){1'b0}}, head_cmd.value};
			end
			dptd_pkg::OP_ADD_TEMP: begin
				temp_d = sat_acc(temp_sum);
			end
			dptd_pkg::OP_SET_DEPTH: begin
				depth_d  = {{(A - VW){1'b0}}, head_cmd.value};
				offset_d = {{(A - VW){1'b0}}, head_cmd.value};
				mult     = 5'd1;
			end
			dptd_pkg::OP_ADD_DEPTH: begin
				depth_d = sat_acc(depth_sum);
				mult    = 5'd1;
			end
			dptd_pkg::OP_TICK: begin
				mult = head_cmd.value[4:0];
			end
			dptd_pkg::OP_ALARM: begin
				// alarms leave time where it is
			end
			default: begin
			end
		endcase
	end

	// Time advance after the record: saturate at the top of the counter
	assign add_secs = 9'(mult * seconds_per_tick);
	assign time_sum = {1'b0, elapsed_q} + (TIME_BITS + 1)'(add_secs);
	assign elapsed_d = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];

	// Record fields, from the updated depth and the pre-advance time
	assign rel_diff = {depth_d[A-1], depth_d} - {offset_d[A-1], offset_d};
	assign rel_acc  = sat_acc(rel_diff);
	assign rel_x    = WX'(rel_acc);
	assign temp_x   = WX'(temp_d);
	assign rel_out  = sat_out(rel_x);
	assign temp_out = sat_out(temp_x);
	assign time_x   = WT'(elapsed_q);
	assign time_out = (time_x > WT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : time_x[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			offset_q    <= '0;
			temp_q      <= '0;
			elapsed_q   <= '0;
			rec_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				depth_q  <= depth_d;
				offset_q <= offset_d;
				temp_q   <= temp_d;
				if (head_cmd.op != dptd_pkg::OP_ALARM) begin
					elapsed_q <= elapsed_d;
				end
			end
			if (out_free) begin
				rec_valid_q <= pop && emits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			record_kind     <= (head_cmd.op == dptd_pkg::OP_ALARM) ?
				dptd_pkg::KIND_ALARM : dptd_pkg::KIND_SAMPLE;
			elapsed_seconds <= time_out;
			relative_depth  <= rel_out;
			temperature     <= temp_out;
			alarm_code      <= (head_cmd.op == dptd_pkg::OP_ALARM) ?
				head_cmd.value[dptd_pkg::CODE_W-1:0] : '0;
		end
	end

	assign record_valid = rec_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && record_stall) |-> !(pop && emits))
		else $error("record overwritten while stalled");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (elapsed_q >= $past(elapsed_q)))
		else $error("elapsed time went backward");

endmodule

>>> rtl/core/dive_profile_token_decoder_top.sv
// ----------------------------------------------------------------------------
// dive_profile_token_decoder_top: dive-log token stream decoder
// Parses a prefix-coded byte stream and emits depth/time samples and alarms.
// ----------------------------------------------------------------------------
// The block takes one byte of the token stream per clock and sustains that
// rate indefinitely while the record side keeps up. A parser works through
// the bytes and hands each finished token other than a mark as a command to
// a two-entry queue; an executer pops one command per cycle unless a stalled
// record holds it up, updates the saturating depth, offset, temperature and
// time accumulators and loads a record register. The byte that completes a
// token writes its command into the queue on acceptance, and the executer
// later pops it and loads the record register. When the record side
// stalls, the queue absorbs up to two more commands before byte_stall rises;
// bytes that only continue a token, and marks, never need queue room once
// accepted. Depth is in units of 1/51.25 m, temperature in 1/2.5 C, both
// held in ACC_BITS-bit signed accumulators and saturated to 24 bits on the
// record; elapsed time lives in a TIME_BITS-bit counter and shows saturated
// to 32 bits. seconds_per_tick sits at byte address 0 of the APB port
// (reset 4) and is meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
module dive_profile_token_decoder_top #(
	parameter int unsigned ACC_BITS  = 24,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         byte_in,
	// record channel
	output logic               record_valid,
	input  logic               record_stall,
	output logic               record_kind,
	output logic [31:0]        elapsed_seconds,
	output logic signed [23:0] relative_depth,
	output logic signed [23:0] temperature,
	output logic [6:0]         alarm_code,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic            take;
	logic            push;
	dptd_pkg::cmd_t  push_cmd;
	logic            q_full;
	logic            head_valid;
	dptd_pkg::cmd_t  head_cmd;
	logic            pop;
	logic [3:0]      spt_q;

	// Configuration: single register, word index taken from paddr[2]
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= dptd_pkg::SPT_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == dptd_pkg::REG_SECONDS_PER_TICK)) begin
			spt_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == dptd_pkg::REG_SECONDS_PER_TICK) ? {28'd0, spt_q} : 32'd0;

	// Hold the byte while the queue has no room for a command
	assign byte_stall = q_full;
	assign take       = byte_valid && !byte_stall;

	dptd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_in (byte_in),
		.push    (push),
		.cmd     (push_cmd)
	);

	dptd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	dptd_back #(
		.ACC_BITS  (ACC_BITS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.seconds_per_tick (spt_q),
		.head_valid       (head_valid),
		.head_cmd         (head_cmd),
		.pop              (pop),
		.record_valid     (record_valid),
		.record_stall     (record_stall),
		.record_kind      (record_kind),
		.elapsed_seconds  (elapsed_seconds),
		.relative_depth   (relative_depth),
		.temperature      (temperature),
		.alarm_code       (alarm_code)
	);

endmodule

>>> tb/dptd_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dptd_record_checker: record predictor and scoreboard of the token decoder
// Watches the byte, record and register channels, decodes every accepted
// byte on its own copy of the decoder state and compares each accepted
// record with the oldest predicted one.
// ----------------------------------------------------------------------------
module dptd_record_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         byte_in,
	input  logic               record_valid,
	input  logic               record_stall,
	input  logic               record_kind,
	input  logic [31:0]        elapsed_seconds,
	input  logic signed [23:0] relative_depth,
	input  logic signed [23:0] temperature,
	input  logic [6:0]         alarm_code,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatch_count,
	output int                 records_pending,
	output int                 records_checked,
	output int                 alarms_checked
);

	localparam logic [2:0] SPT_ADDR = 3'(4 * dptd_pkg::REG_SECONDS_PER_TICK);
	localparam longint DEPTH_TEMP_MAX = 64'sd8388607;
	localparam longint DEPTH_TEMP_MIN = -DEPTH_TEMP_MAX - 1;
	localparam longint ELAPSED_MAX = 64'sd4294967295;

	typedef struct packed {
		logic               kind;
		logic [31:0]        secs;
		logic signed [23:0] depth;
		logic signed [23:0] temp;
		logic [6:0]         code;
	} record_t;

	dptd_pkg::phase_t parse_phase;
	logic [7:0] lead_byte;
	logic [7:0] first_data;
	logic [3:0] tick_seconds;
	longint     depth_acc;
	longint     depth_zero;
	longint     temp_acc;
	longint     elapsed;
	record_t    expected_records[$];

	function automatic longint clamp_acc(input longint v);
		if (v > DEPTH_TEMP_MAX)
			return DEPTH_TEMP_MAX;
		if (v < DEPTH_TEMP_MIN)
			return DEPTH_TEMP_MIN;
		return v;
	endfunction

	function automatic longint sign_ext(input longint raw, input int bits);
		longint span;
		span = longint'(1) << bits;
		raw = raw & (span - 1);
		return raw[bits-1] ? raw - span : raw;
	endfunction

	task automatic push_record(input logic kind, input logic [6:0] code);
		record_t rec;
		rec.kind  = kind;
		rec.secs  = 32'(elapsed);
		rec.depth = 24'(clamp_acc(depth_acc - depth_zero));
		rec.temp  = 24'(clamp_acc(temp_acc));
		rec.code  = code;
		expected_records.push_back(rec);
	endtask

	// emit a sample, then advance time by mult ticks, saturating
	task automatic tick_sample(input longint mult);
		longint step;
		step = mult * longint'(tick_seconds);
		push_record(dptd_pkg::KIND_SAMPLE, '0);
		if (step > ELAPSED_MAX - elapsed)
			elapsed = ELAPSED_MAX;
		else
			elapsed = elapsed + step;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [6:0] code;
		case (parse_phase)
			dptd_pkg::PH_ALARM: begin
				parse_phase = dptd_pkg::PH_LEAD;
				code = b[6:0];
				if (b[7] || code == 0 || (code & (code - 7'd1)) != 0)
					code = '0;
				push_record(dptd_pkg::KIND_ALARM, code);
			end
			dptd_pkg::PH_TEMP_HI: begin
				first_data = b;
				parse_phase = dptd_pkg::PH_TEMP_LO;
			end
			dptd_pkg::PH_TEMP_LO: begin
				parse_phase = dptd_pkg::PH_LEAD;
				temp_acc = clamp_acc(longint'({first_data, b}));
			end
			dptd_pkg::PH_DEPTH_HI: begin
				first_data = b;
				parse_phase = dptd_pkg::PH_DEPTH_LO;
			end
			dptd_pkg::PH_DEPTH_LO: begin
				parse_phase = dptd_pkg::PH_LEAD;
				depth_acc = clamp_acc(longint'({lead_byte[0], first_data, b}));
				depth_zero = depth_acc;
				tick_sample(1);
			end
			dptd_pkg::PH_TDELTA_LO: begin
				parse_phase = dptd_pkg::PH_LEAD;
				temp_acc = clamp_acc(temp_acc + sign_ext(longint'({lead_byte[1:0], b}), 10));
			end
			dptd_pkg::PH_DDELTA_LO: begin
				parse_phase = dptd_pkg::PH_LEAD;
				depth_acc = clamp_acc(depth_acc + sign_ext(longint'({lead_byte[2:0], b}), 11));
				tick_sample(1);
			end
			default: begin
				lead_byte = b;
				casez (b)
					8'b1111_1111: parse_phase = dptd_pkg::PH_ALARM;
					8'b1111_1110: parse_phase = dptd_pkg::PH_TEMP_HI;
					8'b1111_110?: parse_phase = dptd_pkg::PH_DEPTH_HI;
					8'b1111_10??: parse_phase = dptd_pkg::PH_TDELTA_LO;
					8'b1111_0???: parse_phase = dptd_pkg::PH_DDELTA_LO;
					8'b1110_????: ;
					8'b110?_????: tick_sample(longint'(b[4:0]));
					8'b10??_????: temp_acc = clamp_acc(temp_acc + sign_ext(longint'(b[5:0]), 6));
					default: begin
						depth_acc = clamp_acc(depth_acc + sign_ext(longint'(b[6:0]), 7));
						tick_sample(1);
					end
				endcase
			end
		endcase
	endtask

	task automatic report_record(input string what, input record_t e, input record_t a);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected kind %0d secs %0d depth %0d temp %0d code %0d,",
				$realtime, what, e.kind, e.secs, e.depth, e.temp, e.code);
			$display("    got kind %0d secs %0d depth %0d temp %0d code %0d",
				a.kind, a.secs, a.depth, a.temp, a.code);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		record_t seen;
		record_t want;
		if (!arst_n) begin
			parse_phase = dptd_pkg::PH_LEAD;
			lead_byte = '0;
			first_data = '0;
			tick_seconds = dptd_pkg::SPT_RESET;
			depth_acc = 0;
			depth_zero = 0;
			temp_acc = 0;
			elapsed = 0;
			expected_records.delete();
			mismatch_count = 0;
			records_pending = 0;
			records_checked = 0;
			alarms_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == SPT_ADDR)
				tick_seconds = pwdata[3:0];
			if (record_valid && !record_stall) begin
				seen.kind  = record_kind;
				seen.secs  = elapsed_seconds;
				seen.depth = relative_depth;
				seen.temp  = temperature;
				seen.code  = alarm_code;
				if (expected_records.size() == 0) begin
					report_record("record with none expected", '0, seen);
				end else begin
					want = expected_records.pop_front();
					records_checked++;
					if (want.kind == dptd_pkg::KIND_ALARM)
						alarms_checked++;
					if (seen.kind !== want.kind || seen.secs !== want.secs
						|| seen.depth !== want.depth || seen.temp !== want.temp
						|| seen.code !== want.code)
						report_record("record mismatch", want, seen);
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(byte_in);
			records_pending = expected_records.size();
		end
	end

endmodule

>>> tb/tb_dive_profile_token_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dive_profile_token_decoder_top: testbench of the dive profile decoder
// Feeds directed and random token streams at several tick settings, with
// random gaps and stalls on both channels and one long record hold-off; a
// side checker predicts and compares every record.
// ----------------------------------------------------------------------------
module tb_dive_profile_token_decoder_top;

	localparam logic [2:0] SPT_ADDR = 3'(4 * dptd_pkg::REG_SECONDS_PER_TICK);
	// leave margin for the queue after the last record
	localparam int SETTLE_CYCLES = 8;
	// longest quiet stretch of a correct run is the long hold plus gaps
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int PHASE_ITEMS = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	logic [7:0]         byte_in = '0;
	logic               record_valid;
	logic               record_stall = 1'b0;
	logic               record_kind;
	logic [31:0]        elapsed_seconds;
	logic signed [23:0] relative_depth;
	logic signed [23:0] temperature;
	logic [6:0]         alarm_code;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int mismatch_count;
	int records_pending;
	int records_checked;
	int alarms_checked;

	// stimulus state; idle_enable and long_hold are shared between processes
	bit         idle_enable = 1'b1;
	int         long_hold = 0;
	int         quiet_cycles = 0;
	int         bytes_sent = 0;
	logic [7:0] stream_bytes[$];

	always #5 clk = ~clk;

	dive_profile_token_decoder_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.byte_in         (byte_in),
		.record_valid    (record_valid),
		.record_stall    (record_stall),
		.record_kind     (record_kind),
		.elapsed_seconds (elapsed_seconds),
		.relative_depth  (relative_depth),
		.temperature     (temperature),
		.alarm_code      (alarm_code),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	dptd_record_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.byte_in         (byte_in),
		.record_valid    (record_valid),
		.record_stall    (record_stall),
		.record_kind     (record_kind),
		.elapsed_seconds (elapsed_seconds),
		.relative_depth  (relative_depth),
		.temperature     (temperature),
		.alarm_code      (alarm_code),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatch_count  (mismatch_count),
		.records_pending (records_pending),
		.records_checked (records_checked),
		.alarms_checked  (alarms_checked)
	);

	// Write seconds_per_tick: setup cycle, then access cycle until pready.
	task automatic write_tick_seconds(input logic [3:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SPT_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Append one token with random content. A small share is a lone random
	// byte, which lands anywhere in the token grammar and so may also break up
	// the token that follows. Marks are ignored and do not count as items.
	task automatic queue_random_token(inout int items);
		logic [7:0] lead;
		logic [7:0] code;
		if ($urandom_range(0, 99) < 8) begin
			stream_bytes.push_back(8'($urandom_range(0, 255)));
			items++;
			return;
		end
		case ($urandom_range(0, 8))
			0: begin
				// alarm: half the time one of the known codes, else any byte
				if ($urandom_range(0, 1) == 0)
					code = 8'(1 << $urandom_range(0, 6));
				else
					code = 8'($urandom_range(0, 255));
				stream_bytes.push_back(8'hFF);
				stream_bytes.push_back(code);
				items += 2;
			end
			1: begin
				stream_bytes.push_back(8'hFE);
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				items += 3;
			end
			2: begin
				stream_bytes.push_back({7'b1111110, 1'($urandom_range(0, 1))});
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				items += 3;
			end
			3: begin
				stream_bytes.push_back({6'b111110, 2'($urandom_range(0, 3))});
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				items += 2;
			end
			4: begin
				stream_bytes.push_back({5'b11110, 3'($urandom_range(0, 7))});
				stream_bytes.push_back(8'($urandom_range(0, 255)));
				items += 2;
			end
			5: stream_bytes.push_back({4'b1110, 4'($urandom_range(0, 15))});
			6: begin
				stream_bytes.push_back({3'b110, 5'($urandom_range(0, 31))});
				items++;
			end
			7: begin
				stream_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
				items++;
			end
			default: begin
				lead = {1'b0, 7'($urandom_range(0, 127))};
				stream_bytes.push_back(lead);
				items++;
			end
		endcase
	endtask

	// Drive the queued bytes, each after a random gap when gaps are enabled, then drop valid.
	// Returning past a falling edge lets the checker see the last byte.
	task automatic send_stream();
		int gap;
		while (stream_bytes.size() > 0) begin
			gap = idle_enable ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			byte_valid <= 1'b1;
			byte_in <= stream_bytes.pop_front();
			do @(posedge clk); while (!(byte_valid && !byte_stall));
			bytes_sent++;
		end
		@(negedge clk);
		byte_valid <= 1'b0;
	endtask

	// Wait until every predicted record is in, then let the pipeline settle
	// so that trailing tokens without a record are done as well.
	task automatic settle();
		wait (records_pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Record side: before each record hold stall for a random number of
	// cycles, or for the long hold-off once it is requested.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_enable ? $urandom_range(0, 12) : 0;
			if (long_hold > 0) begin
				gap = long_hold;
				long_hold = 0;
			end
			if (gap > 0) begin
				@(negedge clk);
				record_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			record_stall <= 1'b0;
			do @(posedge clk); while (!(record_valid && !record_stall));
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (record_valid && !record_stall)
			|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("dive_profile_token_decoder_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [3:0] tick_settings[5];
		int items;
		tick_settings[0] = 4'd1;
		tick_settings[1] = 4'd0;
		tick_settings[2] = 4'($urandom_range(2, 14));
		tick_settings[3] = 4'd15;
		tick_settings[4] = 4'd7;

		// hold reset, then release it between edges
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the largest tick: known and unknown alarm codes
		// (0xFF as a code byte too), extreme absolute temperature and depth,
		// extreme long and short deltas of both kinds, a mark, the largest
		// and a zero time multiplier.
		write_tick_seconds(4'd15);
		stream_bytes = {8'hFF, 8'h01, 8'hFF, 8'h40, 8'hFF, 8'hFF,
			8'hFE, 8'hFF, 8'hFF, 8'hFD, 8'hFF, 8'hFF,
			8'hFA, 8'h00, 8'hF4, 8'h00, 8'hF3, 8'hFF, 8'hEF,
			8'hDF, 8'hC0, 8'hA0, 8'h9F, 8'h40, 8'h3F, 8'h00};
		send_stream();
		settle();

		// Random phases, one tick setting each. The second phase runs with
		// no gaps on either side; the third opens with the long hold-off so
		// the decoder queue fills and the byte side stalls.
		for (int ph = 0; ph < 5; ph++) begin
			write_tick_seconds(tick_settings[ph]);
			idle_enable = (ph != 1);
			if (ph == 2)
				long_hold = LONG_HOLD;
			items = 0;
			while (items < PHASE_ITEMS)
				queue_random_token(items);
			send_stream();
			settle();
		end

		$display("run covered %0d bytes in six phases, tick settings from 0 to 15",
			bytes_sent);
		$display("%0d records checked, %0d of them alarms, %0d mismatches",
			records_checked, alarms_checked, mismatch_count);
		if (mismatch_count == 0 && records_pending == 0)
			$display("dive_profile_token_decoder_top test passed");
		else
			$display("dive_profile_token_decoder_top test failed");
		$finish;
	end

endmodule
